@@ rtl/aesbe_pkg.sv @@
// ----------------------------------------------------------------------------
// aesbe_pkg: shared types, constants and functions
// Payload structs, S-box table and GF(2^8) helpers of the block cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package aesbe_pkg;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  key_slot;
    logic [63:0] key_data;
    logic [63:0] text_hi;
    logic [63:0] text_lo;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_beat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    gf_double = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // SubBytes, ShiftRows and optional MixColumns on a state, byte 0 at the top.
  function automatic logic [127:0] round_core(input logic [127:0] st, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] d [4];
    logic [127:0] res;
    for (int k = 0; k < 16; k++) b[k] = st[127-8*k -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = SBOX[b[4*((c+r)%4)+r]];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) d[r] = gf_double(t[4*c+r]);
      m[4*c]   = d[0] ^ d[1] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ d[1] ^ d[2] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ d[2] ^ d[3] ^ t[4*c+3];
      m[4*c+3] = d[0] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ d[3];
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = mix ? m[k] : t[k];
    round_core = res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/aesbe_round.sv @@
// ----------------------------------------------------------------------------
// aesbe_round: one cipher round cell
// Registered round: S-box, row shift, optional column mix, round key add.
// ----------------------------------------------------------------------------
`default_nettype none
module aesbe_round #(
  parameter bit LAST = 1'b0
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  input  wire logic         vin,
  input  wire logic [127:0] din,
  input  wire logic [127:0] rkey,
  output logic              vout,
  output logic [127:0]      dout
);
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= aesbe_pkg::round_core(din, !LAST) ^ rkey;
    end
  end
endmodule
`default_nettype wire

@@ rtl/aes_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt: AES block encryption with loaded round keys
// Round-unrolled pipeline, one round cell per round, one block per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): a beat with opcode load writes
//   one 64-bit round-key word at key_slot (slots past the store are dropped)
//   and gives no result; a beat with opcode encrypt carries one block.
//   out channel (out_valid/out_ready/out_data): one beat per encrypted block.
// Pipeline: ROUNDS+1 registers, one for the initial key add and one round cell
// per round; out_valid comes from the last cell with no extra output stage:
// the last cell is the output register.
// Throughput: one encrypt beat per cycle unless the chain is stalled; the whole
// chain advances as one. Key loads apply to blocks accepted afterwards: a load
// beat waits with in_ready low until every block in flight has left the chain.
// Reset: clears all stage valid bits; the key store is undefined until
// written and needs every word loaded before the first encrypt.
// Stall: when out_ready is low and the last cell holds a result, the whole
// chain holds and in_ready drops; an empty last cell lets the chain advance.
`default_nettype none
module aes_block_encrypt #(
  parameter int ROUNDS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire aesbe_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aesbe_pkg::out_beat_t     out_data
);
  localparam int KEY_WORDS = 2 * (ROUNDS + 1);
  localparam int SW = $clog2(KEY_WORDS);

  logic [63:0] key_mem [KEY_WORDS];
  logic        adv;
  logic        busy;
  logic        v   [ROUNDS+1];
  logic [127:0] s  [ROUNDS+1];

  // Hold the chain only when a finished result is stalled at the output.
  assign adv = out_ready || !v[ROUNDS];

  // Any block still in the chain.
  always_comb begin
    busy = 1'b0;
    for (int r = 0; r <= ROUNDS; r++) busy = busy | v[r];
  end

  // Hold a load beat until the chain is empty so blocks in flight keep their keys.
  assign in_ready = adv && !(in_valid && in_data.opcode == aesbe_pkg::OP_LOAD && busy);

  // Key store: written by load beats, read at fixed words per stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.opcode == aesbe_pkg::OP_LOAD &&
        in_data.key_slot < 5'(KEY_WORDS)) begin
      key_mem[in_data.key_slot[SW-1:0]] <= in_data.key_data;
    end
  end

  // Stage 0: initial key add.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid && in_ready && in_data.opcode == aesbe_pkg::OP_ENCRYPT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s[0] <= {in_data.text_hi, in_data.text_lo} ^ {key_mem[0], key_mem[1]};
    end
  end

  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    aesbe_round #(.LAST(r == ROUNDS)) u_round (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .vin  (v[r-1]),
      .din  (s[r-1]),
      .rkey ({key_mem[2*r], key_mem[2*r+1]}),
      .vout (v[r]),
      .dout (s[r])
    );
  end

  assign out_valid          = v[ROUNDS];
  assign out_data.cipher_hi = s[ROUNDS][127:64];
  assign out_data.cipher_lo = s[ROUNDS][63:0];
endmodule
`default_nettype wire

@@ rtl/aesbe_checker.sv @@
// ----------------------------------------------------------------------------
// aesbe_checker: port-level checks of the cipher block
// Handshake and flow-control properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module aesbe_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire aesbe_pkg::out_beat_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped or changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid |-> in_ready)
    else $error("input held with empty output");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
endmodule

bind aes_block_encrypt aesbe_checker u_aesbe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
